[design/arc_pkg.sv]
`default_nettype none
package arc_pkg;

  localparam int ARC_MAX_LOOPS = 1023;
  localparam int ARC_FRAC      = 30;
  localparam int ARC_XW        = 31;
  localparam int ARC_MW        = 31;
  localparam int ARC_NW_MIN    = 32;

  localparam logic [63:0] ARC_PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic [63:0] ARC_PI_W   = (ARC_PI_Q60 + (64'd1 << (59 - ARC_FRAC)))
                                       >> (60 - ARC_FRAC);
  localparam logic [63:0] ARC_HALF_PI = (ARC_PI_Q60 + (64'd1 << (60 - ARC_FRAC)))
                                        >> (61 - ARC_FRAC);
  localparam logic [31:0] ARC_PI_OUT  = 32'd3373259426;
  localparam logic [30:0] ARC_EPS_RST = 31'd1074;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_X2,
    OP_MUL_P3,
    OP_MUL_PC,
    OP_DIV_CAND,
    OP_CHECK,
    OP_DIV_Q,
    OP_MUL_QK,
    OP_MUL_RK,
    OP_DIV_COEF,
    OP_MUL_PW,
    OP_FINAL,
    OP_OUT
  } arc_op_e;

  typedef struct packed {
    arc_op_e op;
    logic    ph;
  } arc_cmd_t;

  typedef struct packed {
    logic cont;
    logic lmax;
    logic div_done;
  } arc_stat_t;

endpackage
`default_nettype wire

[design/arc_if.sv]
`default_nettype none
interface arc_in_if;
  logic        valid;
  logic        ready;
  logic [30:0] arg_x;
  modport source (output valid, output arg_x, input ready);
  modport sink   (input valid, input arg_x, output ready);
endinterface

interface arc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] arccos_value;
  logic [10:0] last_index;
  logic        not_converged;
  modport source (output valid, output arccos_value, output last_index,
                  output not_converged, input ready);
  modport sink   (input valid, input arccos_value, input last_index,
                  input not_converged, output ready);
endinterface
`default_nettype wire

[design/arc_div.sv]
`default_nettype none
module arc_div #(
  parameter int NW = 32,
  parameter int DW = 12
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic               done_o,
  output logic [NW-1:0]      quo_o,
  output logic [DW-1:0]      rem_o
);
  localparam int CW = $clog2(NW + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] rem_q, den_q;
  logic [NW-1:0] quo_q;
  logic [DW:0]   trial;
  logic          ge;
  logic [DW-1:0] rem_d;

  // Restoring division, one quotient bit per cycle; the numerator shifts
  // out of the top of quo_q while quotient bits shift in at the bottom.
  always_comb begin
    trial = {rem_q, quo_q[NW-1]};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_i;
      quo_q <= num_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[NW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
endmodule
`default_nettype wire

[design/arc_datapath.sv]
`default_nettype none
module arc_datapath import arc_pkg::*; #(
  parameter int MAX_LOOPS = ARC_MAX_LOOPS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire arc_cmd_t    cmd_i,
  output arc_stat_t        stat_o,
  input  wire logic [30:0] eps_i,
  input  wire logic [30:0] arg_x_i,
  output logic [31:0]      arccos_value_o,
  output logic [10:0]      last_index_o,
  output logic             not_converged_o
);
  localparam int DW = $clog2(2 * MAX_LOOPS + 4);
  localparam int LW = $clog2(MAX_LOOPS + 1);
  localparam int SW = ARC_XW + 1 + LW;
  localparam int NW = (2 * DW + 1 > ARC_NW_MIN) ? 2 * DW + 1 : ARC_NW_MIN;
  localparam int PW = 2 * ARC_MW;
  localparam int RW = 2 * DW;

  logic [ARC_MW-1:0] xm_q, x2_q, pw_q, coef_q, cm_q, pm_q, qk_q;
  logic [RW-1:0]     rk_q;
  logic              sx_q, stuck_q;
  logic [DW-1:0]     k_q;
  logic [LW-1:0]     loops_q;
  logic signed [SW-1:0] sum_q;
  logic [31:0]       res_q;
  logic [PW-1:0]     prod_q;
  logic [31:0]       av_q;
  logic [10:0]       li_q;
  logic              nc_q;

  logic [ARC_MW-1:0] ma, mb, prod_rnd, diff;
  logic [PW-1:0]     prod_r;
  logic              is_mul, is_div;
  logic              div_start, div_done;
  logic [NW-1:0]     div_num, div_quo;
  logic [DW-1:0]     div_den, div_rem, k1, k2;
  logic signed [SW-1:0] rs;

  assign k1 = k_q + DW'(1);
  assign k2 = k_q + DW'(2);

  always_comb begin
    is_mul = 1'b1;
    ma     = xm_q;
    mb     = xm_q;
    case (cmd_i.op)
      OP_MUL_X2: begin ma = xm_q;  mb = xm_q; end
      OP_MUL_P3: begin ma = x2_q;  mb = xm_q; end
      OP_MUL_PC: begin ma = pw_q;  mb = coef_q; end
      OP_MUL_PW: begin ma = pw_q;  mb = x2_q; end
      OP_MUL_QK: begin ma = div_quo[ARC_MW-1:0]; mb = ARC_MW'(k_q); end
      OP_MUL_RK: begin ma = ARC_MW'(div_rem);    mb = ARC_MW'(k_q); end
      default:   is_mul = 1'b0;
    endcase
  end

  always_comb begin
    is_div  = 1'b1;
    div_num = NW'(cm_q) + NW'(k2 >> 1);
    div_den = k2;
    case (cmd_i.op)
      OP_DIV_CAND: begin div_num = NW'(cm_q) + NW'(k2 >> 1); div_den = k2; end
      OP_DIV_Q:    begin div_num = NW'(coef_q);              div_den = k1; end
      OP_DIV_COEF: begin div_num = NW'(rk_q) + NW'(k1 >> 1); div_den = k1; end
      default:     is_div = 1'b0;
    endcase
  end

  assign div_start = is_div && !cmd_i.ph;

  arc_div #(.NW(NW), .DW(DW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  // Products are rounded to nearest on the magnitude; signs are tracked apart.
  assign prod_r   = prod_q + (PW'(1) << (ARC_FRAC - 1));
  assign prod_rnd = prod_r[ARC_FRAC +: ARC_MW];

  // Every term carries the sign of x, so the term difference is one of magnitudes.
  assign diff = (cm_q >= pm_q) ? cm_q - pm_q : pm_q - cm_q;

  assign stat_o.cont     = diff >= eps_i;
  assign stat_o.lmax     = loops_q == LW'(MAX_LOOPS);
  assign stat_o.div_done = div_done;

  assign rs = SW'(ARC_HALF_PI) - sum_q;

  always_ff @(posedge clk_i) begin
    if (is_mul && !cmd_i.ph) begin
      prod_q <= ma * mb;
    end
    case (cmd_i.op)
      OP_LOAD: begin
        sx_q    <= arg_x_i[30];
        xm_q    <= arg_x_i[30] ? ~arg_x_i + 31'd1 : arg_x_i;
        pm_q    <= arg_x_i[30] ? ~arg_x_i + 31'd1 : arg_x_i;
        sum_q   <= SW'($signed(arg_x_i));
        coef_q  <= ARC_MW'(1) << (ARC_FRAC - 1);
        k_q     <= DW'(1);
        loops_q <= '0;
        stuck_q <= 1'b0;
      end
      OP_MUL_X2: if (cmd_i.ph) x2_q <= prod_rnd;
      OP_MUL_P3: if (cmd_i.ph) pw_q <= prod_rnd;
      OP_MUL_PC: if (cmd_i.ph) cm_q <= prod_rnd;
      OP_MUL_PW: if (cmd_i.ph) pw_q <= prod_rnd;
      OP_MUL_QK: if (cmd_i.ph) qk_q <= prod_q[ARC_MW-1:0];
      OP_MUL_RK: if (cmd_i.ph) rk_q <= prod_q[RW-1:0];
      OP_DIV_CAND: if (cmd_i.ph && div_done) cm_q <= div_quo[ARC_MW-1:0];
      OP_DIV_COEF: if (cmd_i.ph && div_done) coef_q <= qk_q + div_quo[ARC_MW-1:0];
      OP_CHECK: begin
        if (stat_o.cont && !stat_o.lmax) begin
          loops_q <= loops_q + LW'(1);
          sum_q   <= sx_q ? sum_q - SW'(cm_q) : sum_q + SW'(cm_q);
          k_q     <= k2;
          pm_q    <= cm_q;
        end else if (stat_o.cont) begin
          stuck_q <= 1'b1;
        end
      end
      OP_FINAL: begin
        if (rs < 0) begin
          res_q <= '0;
        end else if (rs > SW'(ARC_PI_W)) begin
          res_q <= 32'(ARC_PI_W);
        end else begin
          res_q <= 32'(rs);
        end
      end
      OP_OUT: begin
        av_q <= (res_q > ARC_PI_OUT) ? ARC_PI_OUT : res_q;
        li_q <= 11'(k_q);
        nc_q <= stuck_q;
      end
      default: ;
    endcase
  end

  assign arccos_value_o  = av_q;
  assign last_index_o    = li_q;
  assign not_converged_o = nc_q;
endmodule
`default_nettype wire

[design/arc_ctrl.sv]
`default_nettype none
module arc_ctrl import arc_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire arc_stat_t stat_i,
  output arc_cmd_t       cmd_o
);
  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_X2   = 13'b0000000000010,
    S_P3   = 13'b0000000000100,
    S_PC   = 13'b0000000001000,
    S_DC   = 13'b0000000010000,
    S_CHK  = 13'b0000000100000,
    S_DQ   = 13'b0000001000000,
    S_QK   = 13'b0000010000000,
    S_RK   = 13'b0000100000000,
    S_DCF  = 13'b0001000000000,
    S_PW   = 13'b0010000000000,
    S_FIN  = 13'b0100000000000,
    S_OUT  = 13'b1000000000000
  } arc_state_e;

  arc_state_e state_q, state_d;
  logic       ph_q, ph_d;
  logic       ov_q, ov_d;
  logic       ld_ok;

  assign ld_ok = !ov_q || out_ready_i;

  always_comb begin
    state_d   = state_q;
    ph_d      = ph_q;
    cmd_o.op  = OP_NONE;
    cmd_o.ph  = ph_q;
    ov_d      = ov_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_X2;
        end
      end
      S_X2:  begin cmd_o.op = OP_MUL_X2;   ph_d = !ph_q; if (ph_q) state_d = S_P3; end
      S_P3:  begin cmd_o.op = OP_MUL_P3;   ph_d = !ph_q; if (ph_q) state_d = S_PC; end
      S_PC:  begin cmd_o.op = OP_MUL_PC;   ph_d = !ph_q; if (ph_q) state_d = S_DC; end
      S_QK:  begin cmd_o.op = OP_MUL_QK;   ph_d = !ph_q; if (ph_q) state_d = S_RK; end
      S_RK:  begin cmd_o.op = OP_MUL_RK;   ph_d = !ph_q; if (ph_q) state_d = S_DCF; end
      S_PW:  begin cmd_o.op = OP_MUL_PW;   ph_d = !ph_q; if (ph_q) state_d = S_PC; end
      // Divide states start the unit, then hold until it reports done.
      S_DC: begin
        cmd_o.op = OP_DIV_CAND;
        ph_d     = 1'b1;
        if (ph_q && stat_i.div_done) begin
          ph_d    = 1'b0;
          state_d = S_CHK;
        end
      end
      S_DQ: begin
        cmd_o.op = OP_DIV_Q;
        ph_d     = 1'b1;
        if (ph_q && stat_i.div_done) begin
          ph_d    = 1'b0;
          state_d = S_QK;
        end
      end
      S_DCF: begin
        cmd_o.op = OP_DIV_COEF;
        ph_d     = 1'b1;
        if (ph_q && stat_i.div_done) begin
          ph_d    = 1'b0;
          state_d = S_PW;
        end
      end
      S_CHK: begin
        cmd_o.op = OP_CHECK;
        state_d  = (stat_i.cont && !stat_i.lmax) ? S_DQ : S_FIN;
      end
      S_FIN: begin
        cmd_o.op = OP_FINAL;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (ld_ok) begin
          cmd_o.op = OP_OUT;
          ov_d     = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ph_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      ov_q    <= ov_d;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = ov_q;
endmodule
`default_nettype wire

[design/arccos_taylor_series_top.sv]
// Channel   Dir  Payload                                       Handshake
// in_i      in   arg_x[30:0] signed Q1.30                      valid/ready
// out_o     out  arccos_value[31:0], last_index, not_converged valid/ready
// cfg       in   cfg_wdata_i[30:0] epsilon                     cfg_we_i, no wait
//
// One item at a time. Setup is the load, three multiplies and one divide. Each
// series term follows a check and adds four multiplies and three 32-step serial
// divides (k+1 twice, k+2).
// Reset clears the controller and loads epsilon to its default; no memories.
// A finished result waits in the output register while the next item runs;
// the last step of an item stalls only if that register is still full.
`default_nettype none
module arccos_taylor_series_top import arc_pkg::*; #(
  parameter int MAX_LOOPS = ARC_MAX_LOOPS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [30:0] cfg_wdata_i,
  arc_in_if.sink           in_i,
  arc_out_if.source        out_o
);
  logic [30:0] eps_q;
  arc_cmd_t    cmd;
  arc_stat_t   stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= ARC_EPS_RST;
    end else if (cfg_we_i) begin
      eps_q <= cfg_wdata_i;
    end
  end

  arc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  arc_datapath #(.MAX_LOOPS(MAX_LOOPS)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .eps_i           (eps_q),
    .arg_x_i         (in_i.arg_x),
    .arccos_value_o  (out_o.arccos_value),
    .last_index_o    (out_o.last_index),
    .not_converged_o (out_o.not_converged)
  );

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.arccos_value <= ARC_PI_OUT)
    else $error("arccos result above pi");

  a_bound_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.not_converged) |->
      out_o.last_index == 11'(2 * MAX_LOOPS + 1))
    else $error("loop bound flag with wrong final index");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("item taken while previous item still in work");
endmodule
`default_nettype wire
